// ===== hdl/glwa_pkg.sv =====
`default_nettype none
package glwa_pkg;

    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_LEFT    = 3'd1;
    localparam logic [2:0] MODE_RIGHT   = 3'd2;
    localparam logic [2:0] MODE_CENTER  = 3'd3;
    localparam logic [2:0] MODE_JUSTIFY = 3'd4;

    localparam logic [1:0] CFG_PARAGRAPH_WIDTH = 2'd0;
    localparam logic [1:0] CFG_SPACE_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_ALIGN_MODE      = 2'd2;

    localparam int INDENT_LIMIT  = 65535;
    localparam int SPACING_LIMIT = 131071;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADD,
        S_START,
        S_DIV,
        S_FORM
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic add_word;
        logic start_div;
        logic load_out;
        logic clear_line;
        logic para_last;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic wrap;
        logic pend;
        logic justify;
        logic cnt_gt1;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/greedy_line_wrap_aligner.sv =====
// A word is latched and checked; if it closes the open line, that line is formed first.
// The word is then added, and a paragraph end forms its line too before the next request.
// A justified line of two or more words that does not end its paragraph first goes through the
// radix-2 divider, one quotient bit a cycle; output back-pressure holds a formed line off.
// A result is registered as its line is formed; the next request is taken while it waits.
// Reset (i_rst_n low, synchronous) clears the configuration, the controller state, the open line and the output valid.
`default_nettype none
module greedy_line_wrap_aligner
    import glwa_pkg::*;
#(
    parameter int MAX_LINE_WORDS = 1023,
    parameter int WIDTH_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // word_width
    input  wire logic        i_s_axis_tlast,   // paragraph_end
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // line_indent, word_spacing, line_words, zero pad
    output logic             o_m_axis_tuser,   // paragraph_last
    output logic             o_m_axis_tlast    // last
);

    t_cmd        cmd;
    t_stat       stat;
    logic [16:0] line_indent;
    logic [16:0] word_spacing;
    logic [9:0]  line_words;

    assign o_cfg_ready = 1'b1;

    glwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    glwa_dp #(
        .MAX_LINE_WORDS(MAX_LINE_WORDS),
        .WIDTH_BITS    (WIDTH_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_word_width     (i_s_axis_tdata),
        .i_paragraph_end  (i_s_axis_tlast),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_line_indent    (line_indent),
        .o_word_spacing   (word_spacing),
        .o_line_words     (line_words),
        .o_paragraph_last (o_m_axis_tuser),
        .o_last           (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, line_words, word_spacing, line_indent};

endmodule
`default_nettype wire

// ===== hdl/glwa_div.sv =====
`default_nettype none
module glwa_div #(
    parameter int NW = 20,
    parameter int DW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic [NW-1:0]      o_quot
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_quot, n_quot;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_div;
    logic [KW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial  = {r_rem, r_quot[NW-1]};
        diff   = trial - {1'b0, r_div};
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = KW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem  = diff[DW-1:0];
                n_quot = {r_quot[NW-2:0], 1'b1};
            end else begin
                n_rem  = trial[DW-1:0];
                n_quot = {r_quot[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== hdl/glwa_ctrl.sv =====
`default_nettype none
module glwa_ctrl
    import glwa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_pl, n_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pl    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pl    <= n_pl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pl       = r_pl;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.para_last = r_pl;
        o_cmd.last      = r_pl | ~i_stat.pend;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.wrap) begin
                    n_pl    = 1'b0;
                    n_state = S_START;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_word = 1'b1;
                if (i_stat.pend) begin
                    n_pl    = 1'b1;
                    n_state = S_START;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                if (i_stat.justify && !r_pl && i_stat.cnt_gt1) begin
                    o_cmd.start_div = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FORM;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_FORM;
                end
            end
            S_FORM: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.clear_line = 1'b1;
                    n_state = r_pl ? S_IDLE : S_ADD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/glwa_dp.sv =====
`default_nettype none
module glwa_dp
    import glwa_pkg::*;
#(
    parameter int MAX_LINE_WORDS = 1023,
    parameter int WIDTH_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [15:0] i_word_width,
    input  wire logic        i_paragraph_end,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [16:0]      o_line_indent,
    output logic [16:0]      o_word_spacing,
    output logic [9:0]       o_line_words,
    output logic             o_paragraph_last,
    output logic             o_last
);

    localparam int CW   = $clog2(MAX_LINE_WORDS + 1);
    localparam int OW   = WIDTH_BITS + 4;
    localparam int LW   = (OW > 16) ? OW : 16;
    localparam int SUMW = LW + 2;
    localparam logic [OW-1:0] WMAX = {OW{1'b1}};
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LINE_WORDS);
    localparam logic signed [LW+1:0] IND_HI = (LW+2)'(INDENT_LIMIT);
    localparam logic signed [LW+1:0] SPC_HI = (LW+2)'(SPACING_LIMIT);

    logic [15:0]   r_pw, r_sw;
    logic [2:0]    r_mode;
    logic [15:0]   r_w;
    logic          r_pend;
    logic [OW-1:0] r_olw;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_out_valid;
    logic [16:0]   r_indent, r_spacing;
    logic [9:0]    r_words;
    logic          r_plast, r_last;

    logic [SUMW-1:0]        sum;
    logic                   wraps;
    logic signed [LW:0]     slack;
    logic signed [LW:0]     slack_adj;
    logic [LW-1:0]          mag;
    logic                   div_busy;
    logic [LW-1:0]          quot;
    logic signed [LW+1:0]   qs;
    logic signed [LW+1:0]   spc_j;
    logic signed [LW+1:0]   ind;
    logic signed [LW+1:0]   ind_c;
    logic signed [LW+1:0]   spc;
    logic signed [LW+1:0]   spc_c;
    logic [CW-1:0]          cnt_m1;

    always_comb begin
        if (r_cnt == '0) begin
            sum = SUMW'(r_w);
        end else begin
            sum = SUMW'(r_olw) + SUMW'(r_sw) + SUMW'(r_w);
        end
        wraps = r_mode inside {[MODE_LEFT:MODE_JUSTIFY]};
    end

    assign slack     = $signed((LW+1)'(r_pw)) - $signed((LW+1)'(r_olw));
    assign mag       = slack[LW] ? LW'(-slack) : slack[LW-1:0];
    assign slack_adj = slack + $signed({{LW{1'b0}}, slack[LW]});
    assign cnt_m1    = r_cnt - 1'b1;

    glwa_div #(
        .NW(LW),
        .DW(CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (mag),
        .i_divisor  (cnt_m1),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    always_comb begin
        qs    = r_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        spc_j = $signed((LW+2)'(r_sw)) + qs;
        ind   = '0;
        spc   = $signed((LW+2)'(r_sw));
        case (r_mode)
            MODE_RIGHT: begin
                ind = (LW+2)'(slack);
            end
            MODE_CENTER: begin
                ind = (LW+2)'(slack_adj >>> 1);
            end
            MODE_JUSTIFY: begin
                if (!i_cmd.para_last) begin
                    spc = (r_cnt > CW'(1)) ? spc_j : '0;
                end
            end
            default: begin
                ind = '0;
            end
        endcase
        if (ind > IND_HI) begin
            ind_c = IND_HI;
        end else if (ind < -IND_HI) begin
            ind_c = -IND_HI;
        end else begin
            ind_c = ind;
        end
        if (spc > SPC_HI) begin
            spc_c = SPC_HI;
        end else if (spc < 0) begin
            spc_c = '0;
        end else begin
            spc_c = spc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw        <= '0;
            r_sw        <= '0;
            r_mode      <= MODE_NONE;
            r_olw       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PARAGRAPH_WIDTH: r_pw   <= i_cfg_data;
                    CFG_SPACE_WIDTH:     r_sw   <= i_cfg_data;
                    CFG_ALIGN_MODE:      r_mode <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear_line) begin
                r_olw <= '0;
                r_cnt <= '0;
            end else if (i_cmd.add_word) begin
                r_olw <= (sum > SUMW'(WMAX)) ? WMAX : sum[OW-1:0];
                if (r_cnt < CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.latch_in) begin
            r_w    <= i_word_width;
            r_pend <= i_paragraph_end;
        end
        if (i_cmd.start_div) begin
            r_neg <= slack[LW];
        end
        if (i_cmd.load_out) begin
            r_indent  <= ind_c[16:0];
            r_spacing <= spc_c[16:0];
            r_words   <= 10'(32'(r_cnt));
            r_plast   <= i_cmd.para_last;
            r_last    <= i_cmd.last;
        end
    end

    always_comb begin
        o_stat.wrap     = wraps && (r_cnt != '0) && (sum > SUMW'(r_pw));
        o_stat.pend     = r_pend;
        o_stat.justify  = (r_mode == MODE_JUSTIFY);
        o_stat.cnt_gt1  = (r_cnt > CW'(1));
        o_stat.div_busy = div_busy;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_indent    = r_indent;
    assign o_word_spacing   = r_spacing;
    assign o_line_words     = r_words;
    assign o_paragraph_last = r_plast;
    assign o_last           = r_last;

endmodule
`default_nettype wire

// ===== tb/greedy_line_wrap_aligner_test.sv =====
`timescale 1ns / 100ps
module greedy_line_wrap_aligner_test
    import glwa_pkg::*;
();

    localparam int          MAX_WORDS     = 1023;
    localparam longint      WIDTH_SAT     = (longint'(1) << 20) - 1;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PRINT_LIMIT   = 40;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [16:0] indent;
        logic [16:0] spacing;
        logic [9:0]  words;
        logic        para_last;
        logic        line_last;
    } t_line;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    greedy_line_wrap_aligner DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // wrapper state as the block should hold it
    logic [15:0] para_width_reg;
    logic [15:0] space_width_reg;
    logic [2:0]  align_reg;
    longint      line_width;
    int          line_count;

    t_line       pending_lines[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_tickets;
    int          hold_served;
    int          hold_left;
    int          quiet_cycles;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic t_line close_line(input logic para_last);
        t_line  r;
        longint slack;
        longint indent;
        longint spacing;
        slack   = longint'(para_width_reg) - line_width;
        indent  = 0;
        spacing = longint'(space_width_reg);
        if (align_reg == MODE_RIGHT) begin
            indent = slack;
        end else if (align_reg == MODE_CENTER) begin
            indent = slack / 2;
        end else if (align_reg == MODE_JUSTIFY && !para_last) begin
            if (line_count > 1)
                spacing = longint'(space_width_reg) + slack / (line_count - 1);
            else
                spacing = 0;
        end
        if (indent < -INDENT_LIMIT) indent = -INDENT_LIMIT;
        if (indent > INDENT_LIMIT)  indent = INDENT_LIMIT;
        if (spacing < 0)             spacing = 0;
        if (spacing > SPACING_LIMIT) spacing = SPACING_LIMIT;
        r.indent    = indent[16:0];
        r.spacing   = spacing[16:0];
        r.words     = line_count[9:0];
        r.para_last = para_last;
        r.line_last = 1'b0;
        return r;
    endfunction

    task automatic predict_word(input logic [15:0] w, input logic pend);
        t_line  lines[$];
        logic   wraps;
        wraps = align_reg >= MODE_LEFT && align_reg <= MODE_JUSTIFY;
        if (wraps && line_count > 0 &&
            line_width + longint'(space_width_reg) + longint'(w) > longint'(para_width_reg)) begin
            lines = {lines, close_line(1'b0)};
            line_width = 0;
            line_count = 0;
        end
        if (line_count == 0)
            line_width = longint'(w);
        else
            line_width = line_width + longint'(space_width_reg) + longint'(w);
        if (line_width > WIDTH_SAT) line_width = WIDTH_SAT;
        if (line_count < MAX_WORDS) line_count++;
        if (pend) begin
            lines = {lines, close_line(1'b1)};
            line_width = 0;
            line_count = 0;
        end
        if (lines.size() > 0) lines[lines.size() - 1].line_last = 1'b1;
        pending_lines = {pending_lines, lines};
    endtask

    task automatic send_word(input logic [15:0] w, input logic pend);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        i_s_axis_tlast  <= pend;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_word(w, pend);
    endtask

    // leaves valid high; config_all lowers it after the last request
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_PARAGRAPH_WIDTH: para_width_reg  = value;
            CFG_SPACE_WIDTH:     space_width_reg = value;
            CFG_ALIGN_MODE:      align_reg       = value[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic config_all(input logic [15:0] pw, input logic [15:0] sw,
                              input logic [15:0] mode_word);
        wait_idle();
        write_reg(CFG_PARAGRAPH_WIDTH, pw);
        write_reg(CFG_SPACE_WIDTH, sw);
        write_reg(CFG_ALIGN_MODE, mode_word);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset settings: no wrapping, zero widths
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b1);
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        config_all(16'd160, 16'd16, {13'd0, MODE_LEFT});
        send_word(16'd48, 1'b0);
        send_word(16'd48, 1'b0);
        send_word(16'd48, 1'b1);
        config_all(16'd160, 16'd16, {13'd0, MODE_RIGHT});
        send_word(16'd48, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd100, 1'b1);
        // odd slack either side of zero
        config_all(16'd160, 16'd16, {13'd0, MODE_CENTER});
        send_word(16'd48, 1'b0);
        send_word(16'd49, 1'b1);
        send_word(16'd199, 1'b1);
        config_all(16'd160, 16'd16, {13'd0, MODE_JUSTIFY});
        send_word(16'd30, 1'b0);
        send_word(16'd30, 1'b0);
        send_word(16'd30, 1'b0);
        send_word(16'd30, 1'b0);
        send_word(16'd40, 1'b1);
        // oversized word alone on a justified line
        send_word(16'd200, 1'b0);
        send_word(16'd10, 1'b1);
        config_all(16'd64, 16'd8, {13'h1FFF, MODE_SPARE_LO});
        send_word(16'd64, 1'b0);
        send_word(16'd64, 1'b1);
        config_all(16'd64, 16'd8, {13'd0, MODE_SPARE_HI});
        send_word(16'hFFFF, 1'b1);
    endtask

    task automatic test_saturation();
        // count and width saturate in an unwrapped line, then the mode changes under it
        config_all(16'd1000, 16'hFFFF, {13'd0, MODE_NONE});
        repeat (MAX_WORDS + 7) send_word(16'hFFFF, 1'b0);
        config_all(16'd1000, 16'hFFFF, {13'd0, MODE_RIGHT});
        send_word(16'd5, 1'b1);
        // negative slack on a justified line gives zero spacing
        config_all(16'd100, 16'd10, {13'd0, MODE_NONE});
        repeat (3) send_word(16'd80, 1'b0);
        config_all(16'd100, 16'd10, {13'd0, MODE_JUSTIFY});
        send_word(16'd0, 1'b1);
    endtask

    task automatic test_backpressure();
        int saved_send;
        int saved_recv;
        saved_send = send_idle_pct;
        saved_recv = recv_idle_pct;
        config_all(16'd64, 16'd0, {13'd0, MODE_LEFT});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_tickets++;
        repeat (39) send_word(16'd64, 1'b0);
        send_word(16'd64, 1'b1);
        wait_idle();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    task automatic random_setting(input logic [2:0] mode_sel);
        logic [15:0] pw;
        logic [15:0] sw;
        logic [15:0] w;
        case ($urandom_range(0, 5))
            0:       pw = 16'd0;
            1:       pw = 16'hFFFF;
            2:       pw = 16'($urandom_range(0, 65535));
            default: pw = 16'($urandom_range(16, 4000));
        endcase
        case ($urandom_range(0, 5))
            0:       sw = 16'd0;
            1:       sw = 16'hFFFF;
            2:       sw = 16'($urandom_range(0, 65535));
            default: sw = 16'($urandom_range(0, 160));
        endcase
        config_all(pw, sw, {13'($urandom_range(0, 8191)), mode_sel});
        repeat (35) begin
            case ($urandom_range(0, 9))
                0:       w = 16'($urandom_range(0, 65535));
                1:       w = 16'hFFFF;
                2:       w = 16'd0;
                default: w = 16'($urandom_range(0, (int'(pw) >> 1) + 1));
            endcase
            send_word(w, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_random(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < 8; k++)
            random_setting(3'(k));
    endtask

    // result checker and receiver side
    always @(posedge i_clk) begin : result_side
        t_line got;
        t_line want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.indent    = o_m_axis_tdata[16:0];
            got.spacing   = o_m_axis_tdata[33:17];
            got.words     = o_m_axis_tdata[43:34];
            got.para_last = o_m_axis_tuser;
            got.line_last = o_m_axis_tlast;
            if (pending_lines.size() == 0) begin
                report_mismatch($sformatf("unexpected line 0x%0h", got));
            end else begin
                want = pending_lines.pop_front();
                compare_field("line_indent", got.indent, want.indent);
                compare_field("word_spacing", got.spacing, want.spacing);
                compare_field("line_words", got.words, want.words);
                compare_field("paragraph_last", got.para_last, want.para_last);
                compare_field("last", got.line_last, want.line_last);
            end
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_served != hold_tickets) begin
            i_m_axis_tready <= 1'b0;
            hold_served     <= hold_tickets;
            hold_left       <= HOLD_CYCLES;
        end else begin
            i_m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        para_width_reg  = '0;
        space_width_reg = '0;
        align_reg       = MODE_NONE;
        line_width      = 0;
        line_count      = 0;
        error_count     = 0;
        hold_tickets    = 0;
        hold_served     = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 30;
        recv_idle_pct   = 84;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_PARAGRAPH_WIDTH;
        i_cfg_data      <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_backpressure();
        test_random(30, 84);
        test_random(84, 30);
        test_random(0, 0);

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
